>>> rtl/gno2d_pkg.sv
package gno2d_pkg;

	// grid and field widths
	localparam int GRID_AW  = 8;               // 256 x 256 table
	localparam int TAB_AW   = 2 * GRID_AW;
	localparam int GRAD_W   = 16;
	localparam int ENTRY_W  = 2 * GRAD_W;
	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int OCT_W    = 4;
	localparam int OCT_MAX  = 8;
	localparam int K_W      = 3;               // octave index 0..7
	localparam int SHIFT_W  = COORD_W + OCT_MAX;
	localparam int RES_W    = 16;

	// datapath widths
	localparam int DX_W     = FRAC_W + 1;      // offset t or t-1
	localparam int DOT_W    = 34;              // corner dot, Q.30
	localparam int FADE_W   = 18;              // fade weight 0..65536
	localparam int AMP_W    = 17;              // amplitude 0..65536
	localparam int PERS_W   = 16;
	localparam int TOT_W    = 56;              // weighted sum
	localparam int WSUM_W   = 20;              // sum of amplitudes
	localparam int DIVR_W   = WSUM_W + 15;     // weight sum * 2^15
	localparam int DCNT_W   = $clog2(TOT_W);

	// phases of one octave
	localparam int PH_W     = 4;
	localparam logic [PH_W-1:0] PH_ADDR  = PH_W'(0);
	localparam logic [PH_W-1:0] PH_RD0   = PH_W'(1);
	localparam logic [PH_W-1:0] PH_RD1   = PH_W'(2);
	localparam logic [PH_W-1:0] PH_RD2   = PH_W'(3);
	localparam logic [PH_W-1:0] PH_RD3   = PH_W'(4);
	localparam logic [PH_W-1:0] PH_DOT3  = PH_W'(5);
	localparam logic [PH_W-1:0] PH_LERPB = PH_W'(6);
	localparam logic [PH_W-1:0] PH_LERPV = PH_W'(7);
	localparam logic [PH_W-1:0] PH_ACC   = PH_W'(8);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam logic CFG_OCTAVES = 1'b0;
	localparam logic CFG_PERSIST = 1'b1;

	localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OCT,
		ST_DIV
	} state_t;

	// integer part wrapped modulo 255 (byte digit sum)
	function automatic logic [GRID_AW-1:0] mod255(input logic [23:0] v);
		logic [9:0] s;
		logic [8:0] f;
		s = 10'(v[23:16]) + 10'(v[15:8]) + 10'(v[7:0]);
		f = 9'(s[9:8]) + 9'(s[7:0]);
		if (f >= 9'd255)
			f = f - 9'd255;
		return f[GRID_AW-1:0];
	endfunction

endpackage

>>> rtl/gno2d_table.sv
module gno2d_table
	import gno2d_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [TAB_AW-1:0]  waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic [TAB_AW-1:0]  raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem_q [0:(1<<TAB_AW)-1];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/gno2d_fade.sv
module gno2d_fade
	import gno2d_pkg::*;
(
	input  logic                     clk,
	input  logic [FRAC_W-1:0]        t,
	output logic signed [FADE_W-1:0] fade
);

	// 6t^5-15t^4+10t^3, three register stages
	logic signed [20:0] a;
	logic signed [37:0] ab_s1;
	logic [31:0]        tt_s1;
	logic [FRAC_W-1:0]  t_s1;
	logic signed [21:0] b_s2;
	logic [FRAC_W-1:0]  c_s2;
	logic [47:0]        ttt;
	logic signed [38:0] bc;

	assign a   = 21'(signed'({5'b0, t}) * 21'sd6) - 21'sd983040;
	assign ttt = 48'(tt_s1) * 48'(t_s1);
	assign bc  = 39'(b_s2) * 39'(signed'({1'b0, c_s2}));

	always_ff @(posedge clk) begin
		ab_s1 <= 38'(a) * 38'(signed'({1'b0, t}));
		tt_s1 <= 32'(t) * 32'(t);
		t_s1  <= t;
		b_s2  <= 22'(ab_s1 >>> 16) + 22'sd655360;
		c_s2  <= ttt[47:32];
		fade  <= FADE_W'(bc >>> 16);
	end

endmodule

>>> rtl/gno2d_div.sv
module gno2d_div
	import gno2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TOT_W-1:0]  dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic              done,
	output logic [TOT_W-1:0]  quotient
);

	// restoring divider, one quotient bit per cycle
	logic [DIVR_W:0]   rem_q;
	logic [TOT_W-1:0]  dvd_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIVR_W:0]   sh;
	logic              fits;

	assign sh       = {rem_q[DIVR_W-1:0], dvd_q[TOT_W-1]};
	assign fits     = sh >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(TOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? sh - {1'b0, dvs_q} : sh;
			dvd_q <= {dvd_q[TOT_W-2:0], fits};
		end
	end

endmodule

>>> rtl/gradient_noise_2d_octaves.sv
// A write word completes at its accept edge; an evaluate word runs the address,
// corner-read, dot, lerp and accumulate phases per octave (four reads on the one table
// port), then 56 bit-serial division steps and a hand-off; done rises as busy falls.
// One evaluate word at a time, with busy high until done; writes leave busy low.
// Reset clears control and config (octaves 1, persistence 0.5), not the 256 x 256 table.
// The receiver cannot stall: done lasts one cycle.
module gradient_noise_2d_octaves
	import gno2d_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cmd,
	input  logic [GRID_AW-1:0]       cell_x,
	input  logic [GRID_AW-1:0]       cell_y,
	input  logic signed [GRAD_W-1:0] gradient_x,
	input  logic signed [GRAD_W-1:0] gradient_y,
	input  logic [COORD_W-1:0]       coord_x,
	input  logic [COORD_W-1:0]       coord_y,
	output logic                     done,
	output logic signed [RES_W-1:0]  noise_value,
	input  logic                     cfg_we,
	input  logic                     cfg_addr,
	input  logic [PERS_W-1:0]        cfg_data
);

	state_t state_q, state_d;

	// config registers
	logic [OCT_W-1:0]  octaves_q;
	logic [PERS_W-1:0] pers_q;
	logic [OCT_W-1:0]  oct_eff;

	// control
	logic [PH_W-1:0] ph_q;
	logic [K_W-1:0]  k_q;
	logic            last_oct;
	logic            accept;
	logic            tab_we;
	logic            div_start;
	logic            div_done;
	logic            done_q;

	// datapath
	logic [COORD_W-1:0]       px_q, py_q;
	logic [GRID_AW-1:0]       x0_q, y0_q, x1, y1;
	logic [FRAC_W-1:0]        fx_q, fy_q;
	logic [SHIFT_W-1:0]       sxw, syw;
	logic [TAB_AW-1:0]        raddr;
	logic [ENTRY_W-1:0]       rdata;
	logic signed [FADE_W-1:0] wx, wy;
	logic signed [DX_W-1:0]   dx, dy;
	logic signed [GRAD_W-1:0] gx, gy;
	logic signed [32:0]       prod_x, prod_y;
	logic signed [DOT_W-1:0]  dot;
	logic signed [DOT_W-1:0]  n00_q, n10_q, n01_q, n11_q;
	logic signed [DOT_W-1:0]  lerpa_q, lerpb_q, v_q;
	logic signed [DOT_W-1:0]  l0, l1, lres;
	logic signed [FADE_W-1:0] ls;
	logic signed [DOT_W:0]    ldiff;
	logic signed [52:0]       lprod;
	logic signed [51:0]       vprod;
	logic [32:0]              ampp;
	logic [AMP_W-1:0]         amp_q;
	logic signed [TOT_W-1:0]  total_q, total_d;
	logic [WSUM_W-1:0]        weight_q, weight_d;
	logic [TOT_W-1:0]         mag;
	logic [TOT_W-1:0]         quot;
	logic                     neg_q;
	logic signed [RES_W-1:0]  noise_q;

	assign accept   = start && !busy;
	assign oct_eff  = (octaves_q == '0) ? OCT_W'(1) :
	                  (octaves_q > OCT_W'(OCT_MAX)) ? OCT_W'(OCT_MAX) : octaves_q;
	assign last_oct = (OCT_W'(k_q) + OCT_W'(1)) == oct_eff;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= OCT_W'(1);
			pers_q    <= PERS_W'(32768);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_OCTAVES: octaves_q <= cfg_data[OCT_W-1:0];
				CFG_PERSIST: pers_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && cmd == CMD_EVAL) state_d = ST_OCT;
			ST_OCT:  if (ph_q == PH_ACC && last_oct) state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = state_q != ST_IDLE;
		tab_we    = state_q == ST_IDLE && start && cmd == CMD_WRITE;
		div_start = state_q == ST_OCT && ph_q == PH_ACC && last_oct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_ADDR;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_DIV && div_done;
			if (state_q == ST_IDLE) begin
				ph_q <= PH_ADDR;
				k_q  <= '0;
			end else if (state_q == ST_OCT) begin
				if (ph_q == PH_ACC) begin
					ph_q <= PH_ADDR;
					k_q  <= k_q + 1'b1;
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

	// point scaled by 2^k: integer part wraps mod 255, low 16 bits are the fraction
	assign sxw = SHIFT_W'(px_q) << k_q;
	assign syw = SHIFT_W'(py_q) << k_q;
	assign x1  = x0_q + 1'b1;
	assign y1  = y0_q + 1'b1;

	// corner reads: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
	always_comb begin
		case (ph_q)
			PH_RD1:  raddr = {x1, y0_q};
			PH_RD2:  raddr = {x0_q, y1};
			PH_RD3:  raddr = {x1, y1};
			default: raddr = {x0_q, y0_q};
		endcase
	end

	gno2d_table u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr ({cell_x, cell_y}),
		.wdata ({gradient_y, gradient_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	gno2d_fade u_fade_x (.clk(clk), .t(fx_q), .fade(wx));
	gno2d_fade u_fade_y (.clk(clk), .t(fy_q), .fade(wy));

	// corner dot: a set top bit on {1,f} gives f-1 in 17-bit two's complement
	assign dx     = signed'({(ph_q == PH_RD2 || ph_q == PH_DOT3), fx_q});
	assign dy     = signed'({(ph_q == PH_RD3 || ph_q == PH_DOT3), fy_q});
	assign gx     = signed'(rdata[GRAD_W-1:0]);
	assign gy     = signed'(rdata[ENTRY_W-1:GRAD_W]);
	assign prod_x = 33'(dx) * 33'(gx);
	assign prod_y = 33'(dy) * 33'(gy);
	assign dot    = DOT_W'(prod_x) + DOT_W'(prod_y);

	// one shared lerp multiplier
	always_comb begin
		case (ph_q)
			PH_LERPB: begin
				l0 = n01_q;
				l1 = n11_q;
				ls = wx;
			end
			PH_LERPV: begin
				l0 = lerpa_q;
				l1 = lerpb_q;
				ls = wy;
			end
			default: begin
				l0 = n00_q;
				l1 = n10_q;
				ls = wx;
			end
		endcase
	end

	assign ldiff = (DOT_W+1)'(l1) - (DOT_W+1)'(l0);
	assign lprod = 53'(ldiff) * 53'(ls);
	assign lres  = l0 + DOT_W'(lprod >>> 16);

	// octave weighting
	assign vprod    = 52'(v_q) * 52'(signed'({1'b0, amp_q}));
	assign total_d  = total_q + TOT_W'(vprod);
	assign weight_d = weight_q + WSUM_W'(amp_q);
	assign ampp     = 33'(amp_q) * 33'(pers_q);
	assign mag      = total_d[TOT_W-1] ? TOT_W'(-total_d) : TOT_W'(total_d);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q     <= coord_x;
			py_q     <= coord_y;
			amp_q    <= AMP_ONE;
			total_q  <= '0;
			weight_q <= '0;
		end
		if (state_q == ST_OCT) begin
			case (ph_q)
				PH_ADDR: begin
					x0_q <= mod255(sxw[SHIFT_W-1:FRAC_W]);
					y0_q <= mod255(syw[SHIFT_W-1:FRAC_W]);
					fx_q <= sxw[FRAC_W-1:0];
					fy_q <= syw[FRAC_W-1:0];
				end
				PH_RD1:  n00_q <= dot;
				PH_RD2:  n10_q <= dot;
				PH_RD3: begin
					n01_q   <= dot;
					lerpa_q <= lres;
				end
				PH_DOT3:  n11_q   <= dot;
				PH_LERPB: lerpb_q <= lres;
				PH_LERPV: v_q     <= lres;
				PH_ACC: begin
					total_q  <= total_d;
					weight_q <= weight_d;
					amp_q    <= ampp[32:16];
				end
				default: ;
			endcase
		end
		if (div_start)
			neg_q <= total_d[TOT_W-1];
		// truncated quotient, saturated to Q1.15
		if (div_done) begin
			if (!neg_q)
				noise_q <= (quot > TOT_W'(32767)) ? RES_W'(32767) : RES_W'(quot);
			else
				noise_q <= (quot > TOT_W'(32768)) ? RES_W'(32768) : RES_W'(-quot);
		end
	end

	gno2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  ({weight_d, 15'b0}),
		.done     (div_done),
		.quotient (quot)
	);

	assign done        = done_q;
	assign noise_value = noise_q;

endmodule

>>> sim/gradient_noise_2d_octaves_checker.sv
`timescale 1ns / 1ps

module gradient_noise_2d_octaves_checker
	import gno2d_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     cmd,
	input  logic [GRID_AW-1:0]       cell_x,
	input  logic [GRID_AW-1:0]       cell_y,
	input  logic signed [GRAD_W-1:0] gradient_x,
	input  logic signed [GRAD_W-1:0] gradient_y,
	input  logic [COORD_W-1:0]       coord_x,
	input  logic [COORD_W-1:0]       coord_y,
	input  logic                     done,
	input  logic signed [RES_W-1:0]  noise_value,
	input  logic                     cfg_we,
	input  logic                     cfg_addr,
	input  logic [PERS_W-1:0]        cfg_data,
	output int                       outstanding,
	output int                       fail_count
);

	logic [ENTRY_W-1:0]     grad_mem [0:(1<<TAB_AW)-1];
	logic [OCT_W-1:0]       octaves_reg;
	logic [PERS_W-1:0]      persist_reg;
	logic signed [RES_W-1:0] noise_q[$];

	function automatic longint fade_weight(input longint t);
		longint a, b, c;
		a = 6 * t - 15 * 65536;
		b = ((a * t) >>> 16) + 10 * 65536;
		c = (t * t * t) >> 32;
		return (b * c) >>> 16;
	endfunction

	function automatic longint mix(input longint n0, input longint n1, input longint s);
		return n0 + (((n1 - n0) * s) >>> 16);
	endfunction

	function automatic longint grad_dot(input int cx, input int cy,
		input longint dx, input longint dy);
		logic [ENTRY_W-1:0] e;
		e = grad_mem[cx * 256 + cy];
		return dx * longint'($signed(e[15:0])) + dy * longint'($signed(e[31:16]));
	endfunction

	function automatic longint octave_noise(input longint px, input longint py, input int k);
		longint sx, sy, fx, fy, wx, wy;
		int x0, y0;
		sx = px << k;
		sy = py << k;
		x0 = int'((sx >> 16) % 255);
		y0 = int'((sy >> 16) % 255);
		fx = sx & 64'hFFFF;
		fy = sy & 64'hFFFF;
		wx = fade_weight(fx);
		wy = fade_weight(fy);
		return mix(mix(grad_dot(x0, y0, fx, fy), grad_dot(x0 + 1, y0, fx - 65536, fy), wx),
			mix(grad_dot(x0, y0 + 1, fx, fy - 65536),
				grad_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), wx), wy);
	endfunction

	function automatic logic signed [RES_W-1:0] fractal_noise(input longint px, input longint py);
		int n;
		longint total, wsum, amp, q;
		n = octaves_reg;
		if (n < 1) n = 1;
		if (n > OCT_MAX) n = OCT_MAX;
		total = 0;
		wsum = 0;
		amp = 65536;
		for (int k = 0; k < n; k++) begin
			total += octave_noise(px, py, k) * amp;
			wsum += amp;
			amp = (amp * longint'(persist_reg)) >> 16;
		end
		q = total / (wsum * 32768);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return RES_W'(q);
	endfunction

	assign outstanding = noise_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_reg <= OCT_W'(1);
			persist_reg <= PERS_W'(32768);
			noise_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_OCTAVES) octaves_reg <= cfg_data[OCT_W-1:0];
				else persist_reg <= cfg_data;
			end
			if (start && !busy) begin
				if (cmd == CMD_WRITE)
					grad_mem[{cell_x, cell_y}] = {gradient_y, gradient_x};
				else
					noise_q.push_back(fractal_noise(coord_x, coord_y));
			end
			if (done) begin
				if (noise_q.size() == 0) begin
					$error("noise_value: unexpected word, actual %0d", noise_value);
					fail_count <= fail_count + 1;
				end else if (noise_value !== noise_q[0]) begin
					$error("noise_value: expected %0d, actual %0d", noise_q[0], noise_value);
					fail_count <= fail_count + 1;
					void'(noise_q.pop_front());
				end else begin
					void'(noise_q.pop_front());
				end
			end
		end
	end

endmodule

>>> sim/gradient_noise_2d_octaves_tb.sv
`timescale 1ns / 1ps

module gradient_noise_2d_octaves_tb;
	import gno2d_pkg::*;

	localparam int IDLE_LIMIT = 5000;   // cycles without any accepted word or delivered result
	localparam int DRAIN_WAIT = 200;    // > one full 8-octave evaluation
	localparam int SQ         = 16;     // table corner loaded before any evaluation

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     cmd;
	logic [GRID_AW-1:0]       cell_x;
	logic [GRID_AW-1:0]       cell_y;
	logic signed [GRAD_W-1:0] gradient_x;
	logic signed [GRAD_W-1:0] gradient_y;
	logic [COORD_W-1:0]       coord_x;
	logic [COORD_W-1:0]       coord_y;
	logic                     done;
	logic signed [RES_W-1:0]  noise_value;
	logic                     cfg_we;
	logic                     cfg_addr;
	logic [PERS_W-1:0]        cfg_data;
	int                       outstanding;
	int                       fail_count;
	int                       idle_cycles;
	int                       n_writes, n_evals, n_cfg;
	int                       oct_set;

	gradient_noise_2d_octaves i_dut (.*);

	gradient_noise_2d_octaves_checker i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any accepted word or delivered result counts as progress
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [GRAD_W-1:0] rand_grad();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return -16'sd16384;
		if (r == 1) return 16'sd16384;
		return GRAD_W'($urandom_range(0, 32768) - 16384);
	endfunction

	// every octave must land its corners inside the loaded corner of the table
	function automatic bit coord_ok(input logic [COORD_W-1:0] v);
		longint s;
		int n;
		n = oct_set;
		if (n < 1) n = 1;
		if (n > OCT_MAX) n = OCT_MAX;
		for (int k = 0; k < n; k++) begin
			s = longint'(v) << k;
			if (((s >> 16) % 255) > longint'(SQ - 2)) return 1'b0;
		end
		return 1'b1;
	endfunction

	// integer part 255*n (wraps to zero) or up to SQ-2 above; fraction free or pinned
	function automatic logic [COORD_W-1:0] rand_coord();
		logic [COORD_W-1:0] v;
		v = '0;
		for (int i = 0; i < 64; i++) begin
			v[31:16] = 16'(255 * $urandom_range(0, 257));
			if ($urandom_range(0, 3) == 0)
				v[31:16] = v[31:16] + 16'($urandom_range(0, SQ - 2));
			v[15:0] = 16'($urandom);
			case ($urandom_range(0, 5))
				0: v[15:0] = 16'h0000;
				1: v[15:0] = 16'hFFFF;
				2: v[15:0] = 16'h8000;
				3: v[15:0] = 16'($urandom_range(0, 7679));
				default: ;
			endcase
			if (coord_ok(v)) return v;
		end
		return {16'(255 * $urandom_range(0, 257)), 16'h0000};
	endfunction

	// one word: start stays up until the block takes it; busy is sampled mid-cycle
	task automatic send_word(input logic c, input logic [GRID_AW-1:0] x,
		input logic [GRID_AW-1:0] y, input logic signed [GRAD_W-1:0] gx,
		input logic signed [GRAD_W-1:0] gy, input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py, input int gap);
		start      <= 1'b1;
		cmd        <= c;
		cell_x     <= x;
		cell_y     <= y;
		gradient_x <= gx;
		gradient_y <= gy;
		coord_x    <= px;
		coord_y    <= py;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		if (c == CMD_WRITE) n_writes++;
		else n_evals++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic eval_at(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
		input int gap);
		send_word(CMD_EVAL, GRID_AW'($urandom), GRID_AW'($urandom), GRAD_W'($urandom),
			GRAD_W'($urandom), px, py, gap);
	endtask

	// half the writes refresh the loaded corner, the rest land anywhere
	task automatic grad_write(input int gap);
		logic [GRID_AW-1:0] x, y;
		if ($urandom_range(0, 1) == 0) begin
			x = GRID_AW'($urandom_range(0, SQ - 1));
			y = GRID_AW'($urandom_range(0, SQ - 1));
		end else begin
			x = GRID_AW'($urandom);
			y = GRID_AW'($urandom);
		end
		send_word(CMD_WRITE, x, y, rand_grad(), rand_grad(), COORD_W'($urandom),
			COORD_W'($urandom), gap);
	endtask

	// registers change only with the block drained and quiet
	task automatic set_reg(input logic idx, input logic [PERS_W-1:0] val);
		start <= 1'b0;
		forever begin
			@(negedge clk);
			if (outstanding == 0 && !busy) break;
		end
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		if (idx == CFG_OCTAVES) oct_set = int'(val[OCT_W-1:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 30) grad_write(pick_gap());
			else eval_at(rand_coord(), rand_coord(), pick_gap());
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = CMD_WRITE;
		cell_x     = '0;
		cell_y     = '0;
		gradient_x = '0;
		gradient_y = '0;
		coord_x    = '0;
		coord_y    = '0;
		cfg_we     = 1'b0;
		cfg_addr   = CFG_OCTAVES;
		cfg_data   = '0;
		n_writes   = 0;
		n_evals    = 0;
		n_cfg      = 0;
		oct_set    = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the corner of the table that evaluations read, plus the wrap entries
		for (int x = 0; x < SQ; x++)
			for (int y = 0; y < SQ; y++)
				send_word(CMD_WRITE, GRID_AW'(x), GRID_AW'(y), rand_grad(), rand_grad(),
					'0, '0, 0);
		for (int x = 254; x < 256; x++)
			for (int y = 254; y < 256; y++)
				send_word(CMD_WRITE, GRID_AW'(x), GRID_AW'(y), rand_grad(), rand_grad(),
					'0, '0, 0);

		// directed: reset settings, then corners of the coordinate space
		eval_at(32'h0000_0000, 32'h0000_0000, 0);
		eval_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		eval_at(32'h00FE_FFFF, 32'h00FE_0000, 0);    // integer part just below the wrap
		eval_at(32'h00FF_8000, 32'h0000_8000, 2);    // integer part at the wrap
		send_word(CMD_WRITE, 8'd0, 8'd0, -16'sd16384, 16'sd16384, '0, '0, 0);
		send_word(CMD_WRITE, 8'd255, 8'd255, 16'sd16384, -16'sd16384, '0, '0, 0);
		eval_at(32'h0000_4000, 32'h0000_C000, 0);
		eval_at(32'h00FE_C000, 32'h00FE_4000, 0);

		set_reg(CFG_OCTAVES, 16'd8);
		set_reg(CFG_PERSIST, 16'd0);                 // only the first octave weighs
		eval_at(32'hFF00_1DFF, 32'h00FF_0FFF, 0);
		eval_at(32'hFFFF_1DFF, 32'h0000_0001, 0);
		set_reg(CFG_PERSIST, 16'hFFFF);
		eval_at(32'hFF00_1DFF, 32'h00FF_0FFF, 3);
		eval_at(32'hFFFF_1DFF, 32'hFFFF_1DFF, 0);
		set_reg(CFG_OCTAVES, 16'd0);                 // zero count acts as one
		eval_at(32'h000E_CDEF, 32'h0005_3456, 0);
		set_reg(CFG_OCTAVES, 16'hFFFF);              // count above max saturates
		eval_at(32'h01FE_1234, 32'h0000_1DFF, 0);

		// random phases over a spread of settings
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: set_reg(CFG_OCTAVES, 16'(p / 4 + 1));
				1: set_reg(CFG_OCTAVES, 16'd8);
				2: set_reg(CFG_OCTAVES, 16'($urandom_range(0, 15)));
				default: set_reg(CFG_OCTAVES, {12'($urandom), 4'($urandom_range(1, 8))});
			endcase
			case ($urandom_range(0, 3))
				0: set_reg(CFG_PERSIST, 16'd0);
				1: set_reg(CFG_PERSIST, 16'hFFFF);
				default: set_reg(CFG_PERSIST, 16'($urandom));
			endcase
			random_phase(115);
		end
		start <= 1'b0;

		// drain, then let any late word show up
		fork
			begin
				forever begin
					@(negedge clk);
					if (outstanding == 0) break;
				end
				repeat (DRAIN_WAIT) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
				$display("Test completed with failures");
				$finish;
			end
		join_any
		disable fork;

		$display("Covered %0d gradient writes and %0d noise evaluations", n_writes, n_evals);
		$display("across %0d register writes (octaves 0..15, persistence 0..max).", n_cfg);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
rtl/gno2d_pkg.sv
rtl/gno2d_table.sv
rtl/gno2d_fade.sv
rtl/gno2d_div.sv
rtl/gradient_noise_2d_octaves.sv
sim/gradient_noise_2d_octaves_checker.sv
sim/gradient_noise_2d_octaves_tb.sv
